// ----- rtl/poi_pkg.sv -----
// Shared types and constants for the planar odometry integrator.
// Holds the input/output item structs, the controller-to-datapath command
// and status structs, the step codes and the CORDIC arctangent table.
`default_nettype none

package poi_pkg;

  // CORDIC geometry: Q4.30 vector, 32-bit binary angle plus a guard bit
  localparam int CORDIC_ITERS = 24;
  localparam int ITER_BITS    = 5;
  localparam int CW           = 34;
  localparam int ZW           = 33;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

  // shared multiplier operand widths and accumulator width
  localparam int MA_W  = 38;
  localparam int MB_W  = 18;
  localparam int ACC_W = 64;

  // 1/(2*pi) in Q0.32, split into two 15-bit halves
  localparam logic signed [MB_W-1:0] INV_HI = 18'sd20860;
  localparam logic signed [MB_W-1:0] INV_LO = 18'sd24796;
  localparam int INV_SPLIT = 15;

  typedef struct packed {
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_lateral;
    logic signed [15:0] yaw_rate;
    logic        [15:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_item_t;

  // datapath steps between the two CORDIC passes
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_VXC,
    STEP_VYS,
    STEP_VXS,
    STEP_VYC,
    STEP_WXDT,
    STEP_WYDT,
    STEP_WDT,
    STEP_WDIH,
    STEP_WDIL,
    STEP_HEAD
  } step_e;

  typedef struct packed {
    logic  load_in;
    logic  cordic_start;
    logic  cordic_new;
    step_e step;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } stat_t;

  function automatic logic [31:0] atan_lut(input logic [ITER_BITS-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/poi_cordic.sv -----
// Iterative rotation-mode CORDIC: cos and sin of a 32-bit binary angle.
// One micro-rotation per cycle; depends on poi_pkg for table and widths.
`default_nettype none

module poi_cordic (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  [31:0]                      angle_i,
  output logic                             done_o,
  output logic signed [poi_pkg::CW-1:0]    cos_o,
  output logic signed [poi_pkg::CW-1:0]    sin_o
);
  import poi_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [ITER_BITS-1:0]   iter_q, iter_d;
  logic signed [CW-1:0]   x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic [1:0]             quad_q, quad_d;

  logic [31:0]            quad_sum;
  logic [31:0]            z_red;
  logic signed [CW-1:0]   x_sh, y_sh;
  logic signed [ZW-1:0]   at;

  always_comb begin
    quad_sum = angle_i + 32'h2000_0000;
    z_red    = angle_i - {quad_sum[31:30], 30'b0};
    x_sh     = x_q >>> iter_q;
    y_sh     = y_q >>> iter_q;
    at       = ZW'(atan_lut(iter_q));

    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;

    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = ZW'(signed'(z_red));
      quad_d = quad_sum[31:30];
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - at;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + at;
      end
      if (iter_q == ITER_BITS'(CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  // undo the quadrant reduction
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/poi_ctrl.sv -----
// Controller FSM: sequences input capture, two CORDIC passes, the
// multiply steps and the output register. Depends on poi_pkg.
`default_nettype none

module poi_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  input  wire poi_pkg::stat_t   stat_i,
  output poi_pkg::cmd_t         cmd_o
);
  import poi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C1,
    ST_C1_WAIT,
    ST_STEP,
    ST_C2,
    ST_C2_WAIT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  function automatic step_e next_step(input step_e s);
    step_e r;
    case (s)
      STEP_VXC:  r = STEP_VYS;
      STEP_VYS:  r = STEP_VXS;
      STEP_VXS:  r = STEP_VYC;
      STEP_VYC:  r = STEP_WXDT;
      STEP_WXDT: r = STEP_WYDT;
      STEP_WYDT: r = STEP_WDT;
      STEP_WDT:  r = STEP_WDIH;
      STEP_WDIH: r = STEP_WDIL;
      STEP_WDIL: r = STEP_HEAD;
      default:   r = STEP_NONE;
    endcase
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.load_in      = accept;
    cmd_o.cordic_start = (state_q == ST_C1) || (state_q == ST_C2);
    cmd_o.cordic_new   = (state_q == ST_C2);
    cmd_o.step         = (state_q == ST_STEP) ? step_q : STEP_NONE;
    cmd_o.load_out     = load_out;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_C1;
      end
      ST_C1: state_d = ST_C1_WAIT;
      ST_C1_WAIT: begin
        if (stat_i.cordic_done) begin
          state_d = ST_STEP;
          step_d  = STEP_VXC;
        end
      end
      ST_STEP: begin
        step_d = next_step(step_q);
        if (step_q == STEP_HEAD) state_d = ST_C2;
      end
      ST_C2: state_d = ST_C2_WAIT;
      ST_C2_WAIT: begin
        if (stat_i.cordic_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // hold the result until its transfer completes
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/poi_datapath.sv -----
// Datapath: input register, pose state, CORDIC unit, one shared multiplier
// with accumulator, rounding and saturation, output register. Uses poi_pkg.
`default_nettype none

module poi_datapath #(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire poi_pkg::in_item_t   in_item_i,
  input  wire poi_pkg::cmd_t       cmd_i,
  output poi_pkg::stat_t           stat_o,
  output poi_pkg::out_item_t       out_item_o
);
  import poi_pkg::*;

  localparam int RS_H = 60 - ANGLE_BITS;
  localparam int SW   = ((POS_BITS > 36) ? POS_BITS : 36) + 1;
  localparam int OW   = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int PW   = MA_W + MB_W;
  localparam int WVW  = 34;
  localparam int DW   = 36;

  localparam logic signed [ACC_W-1:0] HALF_14 = ACC_W'(1) <<< 13;
  localparam logic signed [ACC_W-1:0] HALF_28 = ACC_W'(1) <<< 27;
  localparam logic signed [ACC_W-1:0] HALF_H  = ACC_W'(1) <<< (RS_H - 1);
  localparam logic signed [CW-1:0]    HALF_16 = CW'(1) <<< 15;

  localparam logic signed [SW-1:0] PMAX =
    {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] PMIN = ~PMAX;
  localparam logic signed [OW-1:0] OMAX = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0] OMIN = ~OMAX;

  in_item_t                   in_q;
  logic [ANGLE_BITS-1:0]      head_q, head_d;
  logic signed [POS_BITS-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [WVW-1:0]      wx_q, wx_d, wy_q, wy_d;
  logic signed [MA_W-1:0]     wd_q, wd_d;
  out_item_t                  out_q;

  logic [31:0]                ang_old, ang_new, ang_sel;
  logic                       cordic_done;
  logic signed [CW-1:0]       cos_v, sin_v;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PW-1:0]       prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic [ACC_W-1:0]           acc_neg;
  logic signed [ACC_W-1:0]    rnd14, rnd28, rndh;
  logic signed [DW-1:0]       delta;
  logic signed [SW-1:0]       pos_base, pos_sum;
  logic signed [POS_BITS-1:0] pos_sat;
  logic signed [OW-1:0]       ox_ext, oy_ext;
  logic signed [CW-1:0]       rq_z, rq_w;
  logic [31:0]                h32;

  // heading as a 32-bit binary angle, and the half angle for the quaternion
  assign ang_old = {head_q, (32 - ANGLE_BITS)'(0)};
  assign ang_new = {1'b0, head_q, (31 - ANGLE_BITS)'(0)};
  assign ang_sel = cmd_i.cordic_new ? ang_new : ang_old;

  poi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .angle_i (ang_sel),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign stat_o.cordic_done = cordic_done;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.step)
      STEP_VXC: begin
        mul_a = MA_W'(cos_v);
        mul_b = MB_W'(in_q.vel_forward);
      end
      STEP_VYS: begin
        mul_a = MA_W'(sin_v);
        mul_b = MB_W'(in_q.vel_lateral);
      end
      STEP_VXS: begin
        mul_a = MA_W'(sin_v);
        mul_b = MB_W'(in_q.vel_forward);
      end
      STEP_VYC: begin
        mul_a = MA_W'(cos_v);
        mul_b = MB_W'(in_q.vel_lateral);
      end
      STEP_WXDT: begin
        mul_a = MA_W'(wx_q);
        mul_b = signed'(MB_W'(in_q.elapsed));
      end
      STEP_WYDT: begin
        mul_a = MA_W'(wy_q);
        mul_b = signed'(MB_W'(in_q.elapsed));
      end
      STEP_WDT: begin
        mul_a = MA_W'(in_q.yaw_rate);
        mul_b = signed'(MB_W'(in_q.elapsed));
      end
      STEP_WDIH: begin
        mul_a = acc_q[MA_W-1:0];
        mul_b = INV_HI;
      end
      STEP_WDIL: begin
        mul_a = wd_q;
        mul_b = INV_LO;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);

  // round to nearest, ties away from zero: add half, less one when negative
  assign acc_neg = {{(ACC_W - 1){1'b0}}, acc_q[ACC_W-1]};
  assign rnd14   = acc_q + HALF_14 - signed'(acc_neg);
  assign rnd28   = acc_q + HALF_28 - signed'(acc_neg);
  assign rndh    = acc_q + HALF_H - signed'(acc_neg);
  assign delta   = rnd28[ACC_W-1:28];

  // one saturating adder serves both axes
  assign pos_base = (cmd_i.step == STEP_WYDT) ? SW'(acc_x_q) : SW'(acc_y_q);
  assign pos_sum  = pos_base + SW'(delta);
  always_comb begin
    if (pos_sum > PMAX) begin
      pos_sat = PMAX[POS_BITS-1:0];
    end else if (pos_sum < PMIN) begin
      pos_sat = PMIN[POS_BITS-1:0];
    end else begin
      pos_sat = pos_sum[POS_BITS-1:0];
    end
  end

  always_comb begin
    acc_d   = acc_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    wd_d    = wd_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    head_d  = head_q;
    case (cmd_i.step)
      STEP_VXC: acc_d = prod_ext;
      STEP_VYS: acc_d = acc_q - prod_ext;
      STEP_VXS: begin
        wx_d  = rnd14[WVW+13:14];
        acc_d = prod_ext;
      end
      STEP_VYC: acc_d = acc_q + prod_ext;
      STEP_WXDT: begin
        wy_d  = rnd14[WVW+13:14];
        acc_d = prod_ext;
      end
      STEP_WYDT: begin
        acc_x_d = pos_sat;
        acc_d   = prod_ext;
      end
      STEP_WDT: begin
        acc_y_d = pos_sat;
        acc_d   = prod_ext;
      end
      STEP_WDIH: begin
        wd_d  = acc_q[MA_W-1:0];
        acc_d = prod_ext;
      end
      STEP_WDIL: acc_d = (acc_q <<< INV_SPLIT) + prod_ext;
      STEP_HEAD: head_d = head_q + rndh[RS_H+ANGLE_BITS-1:RS_H];
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      head_q  <= head_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  // output formatting: clamp to 32 bits, round quaternion to Q1.14
  assign ox_ext = OW'(acc_x_q);
  assign oy_ext = OW'(acc_y_q);
  assign rq_z   = sin_v + HALF_16 - signed'(CW'(sin_v[CW-1]));
  assign rq_w   = cos_v + HALF_16 - signed'(CW'(cos_v[CW-1]));
  assign h32    = {head_q, (32 - ANGLE_BITS)'(0)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_item_i;
    acc_q <= acc_d;
    wx_q  <= wx_d;
    wy_q  <= wy_d;
    wd_q  <= wd_d;
    if (cmd_i.load_out) begin
      out_q.pos_x   <= (ox_ext > OMAX) ? 32'sh7FFF_FFFF :
                       (ox_ext < OMIN) ? 32'sh8000_0000 : ox_ext[31:0];
      out_q.pos_y   <= (oy_ext > OMAX) ? 32'sh7FFF_FFFF :
                       (oy_ext < OMIN) ? 32'sh8000_0000 : oy_ext[31:0];
      out_q.heading <= h32[31:16];
      out_q.quat_z  <= rq_z[31:16];
      out_q.quat_w  <= rq_w[31:16];
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/planar_odometry_integrator_core.sv -----
// Planar dead-reckoning odometry integrator, top level: controller + datapath.
// One item at a time: a new tick is taken only after the previous result has
// been loaded into the output register, following two 24-step CORDIC
// passes and ten steps on the one shared multiplier.
// Reset (rst_ni low, asynchronous) clears position, heading and handshakes.
`default_nettype none

module planar_odometry_integrator_core #(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire poi_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output poi_pkg::out_item_t       out_item_o
);
  import poi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: take a tick only when idle, run CORDIC on the old heading,
  // step the multiplier through rotation, time scaling and heading advance,
  // run CORDIC on the new half heading, then load the output register.
  // The output register holds the result until its transfer completes.
  poi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: pose accumulators (saturating position, wrapping heading),
  // CORDIC unit, shared multiplier with accumulator, output register.
  poi_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .POS_BITS   (POS_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
